@@ hdl/bpg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpg_pkg
// Shared types and constants for the button power gesture control block.
// ----------------------------------------------------------------------------
package bpg_pkg;

  // Width of the click hold counter (valid range 9 to 32)
  localparam int HeldCounterBits = 16;

  localparam int RegBits   = 8;
  localparam int HoldBits  = 8;
  localparam int WaitBits  = 9;
  localparam int TallyBits = 2;
  localparam int CfgIdxBits = 2;

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgClickWindow    = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgLongPressLimit = 2'd1;

  // Register reset values
  localparam logic [RegBits-1:0] ClickWindowReset    = 8'd60;
  localparam logic [RegBits-1:0] LongPressLimitReset = 8'd150;

  // Beep counts
  localparam logic [2:0] BeepNone = 3'd0;
  localparam logic [2:0] BeepOn   = 3'd5;
  localparam logic [2:0] BeepOff  = 3'd3;

  // Click detector results
  localparam logic [1:0] ClickNone   = 2'd0;
  localparam logic [1:0] ClickSingle = 2'd1;
  localparam logic [1:0] ClickDouble = 2'd2;

  // Saturation limits
  localparam logic [HoldBits-1:0]        HoldMax = {HoldBits{1'b1}};
  localparam logic [WaitBits-1:0]        WaitMax = {WaitBits{1'b1}};
  localparam logic [HeldCounterBits-1:0] HeldMax = {HeldCounterBits{1'b1}};

  typedef enum logic [1:0] {
    PWR_OFF          = 2'd0,
    PWR_ON           = 2'd1,
    PWR_SWITCHED_OFF = 2'd2
  } power_state_t;

  // One tick item as seen by the detector
  typedef struct packed {
    logic key_level;
    logic startup_done;
    logic others_active;
  } tick_t;

  // One result item
  typedef struct packed {
    logic [1:0] power_mode;
    logic [2:0] beep_request;
    logic [1:0] click_event;
    logic       long_press_event;
  } result_t;

endpackage : bpg_pkg
`default_nettype wire

@@ hdl/bpg_detect.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bpg_detect
// Power state, long-press and click detectors. Computes the result of one
// tick combinationally and commits the detector state when fire is high.
// ----------------------------------------------------------------------------
module bpg_detect (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          fire,
  input  wire bpg_pkg::tick_t                tick,
  input  wire logic [bpg_pkg::RegBits-1:0]   click_window,
  input  wire logic [bpg_pkg::RegBits-1:0]   long_press_limit,
  output bpg_pkg::result_t                   res
);

  bpg_pkg::power_state_t                   power_state, power_state_next;
  logic [bpg_pkg::HoldBits-1:0]            hold_ticks, hold_ticks_next;
  logic                                    long_fired, long_fired_next;
  logic                                    press_seen, press_seen_next;
  logic                                    press_counted, press_counted_next;
  logic [bpg_pkg::TallyBits-1:0]           press_tally, press_tally_next;
  logic [bpg_pkg::WaitBits-1:0]            wait_ticks, wait_ticks_next;
  logic [bpg_pkg::HeldCounterBits-1:0]     held_ticks, held_ticks_next;

  logic                                    long_run, click_run;
  logic [bpg_pkg::HeldCounterBits-1:0]     cw_held;
  logic [bpg_pkg::WaitBits-1:0]            cw_wait;

  assign cw_held = bpg_pkg::HeldCounterBits'(click_window);
  assign cw_wait = bpg_pkg::WaitBits'(click_window);

  assign long_run  = tick.startup_done && (power_state == bpg_pkg::PWR_OFF)
                     && !tick.others_active;
  assign click_run = !long_run && (power_state == bpg_pkg::PWR_ON) && !tick.others_active;

  // Next state and result of one tick
  always_comb begin
    logic done;
    power_state_next   = power_state;
    hold_ticks_next    = hold_ticks;
    long_fired_next    = long_fired;
    press_seen_next    = press_seen;
    press_counted_next = press_counted;
    press_tally_next   = press_tally;
    wait_ticks_next    = wait_ticks;
    held_ticks_next    = held_ticks;
    res.beep_request     = bpg_pkg::BeepNone;
    res.click_event      = bpg_pkg::ClickNone;
    res.long_press_event = 1'b0;
    done = 1'b0;

    if (long_run) begin
      // Long-press detector, saturating hold count
      if (!long_fired && !tick.key_level) begin
        if (hold_ticks != bpg_pkg::HoldMax) hold_ticks_next = hold_ticks + 1'b1;
      end else begin
        hold_ticks_next = '0;
      end
      if (hold_ticks_next > long_press_limit) begin
        long_fired_next      = 1'b1;
        hold_ticks_next      = '0;
        res.long_press_event = 1'b1;
        res.beep_request     = bpg_pkg::BeepOn;
        power_state_next     = bpg_pkg::PWR_ON;
      end else begin
        long_fired_next = 1'b0;
      end
    end else if (click_run) begin
      // Click detector
      if (!tick.key_level) begin
        if (held_ticks != bpg_pkg::HeldMax) held_ticks_next = held_ticks + 1'b1;
      end else begin
        held_ticks_next = '0;
      end
      if (!tick.key_level) press_seen_next = 1'b1;
      if (!press_counted) begin
        if (press_seen_next) begin
          press_tally_next   = press_tally + 1'b1;
          press_counted_next = 1'b1;
        end
        if (press_tally_next == 2'd2) begin
          press_tally_next = '0;
          wait_ticks_next  = '0;
          res.click_event  = bpg_pkg::ClickDouble;
          res.beep_request = bpg_pkg::BeepOff;
          power_state_next = bpg_pkg::PWR_SWITCHED_OFF;
          done = 1'b1;
        end
      end
      if (!done) begin
        if (tick.key_level) begin
          press_seen_next    = 1'b0;
          press_counted_next = 1'b0;
        end
        if (press_tally_next == 2'd1) begin
          if (wait_ticks != bpg_pkg::WaitMax) wait_ticks_next = wait_ticks + 1'b1;
          if (wait_ticks_next > cw_wait && held_ticks_next < cw_held) begin
            press_tally_next = '0;
            wait_ticks_next  = '0;
            res.click_event  = bpg_pkg::ClickSingle;
          end else if (held_ticks_next > cw_held) begin
            // held too long for a click: drop the pending press
            press_tally_next = '0;
            wait_ticks_next  = '0;
          end
        end
      end
    end
    res.power_mode = power_state_next;
  end

  // Detector state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      power_state   <= bpg_pkg::PWR_OFF;
      hold_ticks    <= '0;
      long_fired    <= 1'b0;
      press_seen    <= 1'b0;
      press_counted <= 1'b0;
      press_tally   <= '0;
      wait_ticks    <= '0;
      held_ticks    <= '0;
    end else if (fire) begin
      power_state   <= power_state_next;
      hold_ticks    <= hold_ticks_next;
      long_fired    <= long_fired_next;
      press_seen    <= press_seen_next;
      press_counted <= press_counted_next;
      press_tally   <= press_tally_next;
      wait_ticks    <= wait_ticks_next;
      held_ticks    <= held_ticks_next;
    end
  end

  // Checks
  a_long_beep: assert property (@(posedge clk) disable iff (rst)
    res.long_press_event |-> (res.beep_request == bpg_pkg::BeepOn)
                             && (res.power_mode == bpg_pkg::PWR_ON))
    else $error("long press without switch-on");

  a_double_beep: assert property (@(posedge clk) disable iff (rst)
    (res.click_event == bpg_pkg::ClickDouble) |->
      (res.beep_request == bpg_pkg::BeepOff))
    else $error("double click without switch-off beep");

  a_off_sticks: assert property (@(posedge clk) disable iff (rst)
    (power_state == bpg_pkg::PWR_SWITCHED_OFF) |=>
      (power_state == bpg_pkg::PWR_SWITCHED_OFF))
    else $error("switched-off state left");

  a_tally_low: assert property (@(posedge clk) disable iff (rst)
    press_tally < 2'd2)
    else $error("press tally not cleared");

  a_fired_clear: assert property (@(posedge clk) disable iff (rst)
    long_fired |-> (hold_ticks == '0))
    else $error("hold count kept after long press");

endmodule : bpg_detect
`default_nettype wire

@@ hdl/button_power_gesture_control_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_power_gesture_control_top
// Button gesture power control: long press switches on, double click off.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item per 100 Hz tick carrying
//   key_level (0 pressed), startup_done and the three other-source flags.
//   Output channel (out_valid / out_stall): one result item per input item:
//   power_mode, beep_request, click_event, long_press_event.
//   Config channel (cfg_valid / cfg_ready): cfg_index 0 writes click_window,
//   1 writes long_press_limit; other indexes are ignored. cfg_ready is
//   always high. Write only while no item is in flight.
//   An accepted item is held in the input register; its result is loaded
//   into the output register when the detector fires and is shown from then.
//   Throughput: one item per clock while the output is not stalled; the input
//   register and output register each hold one item.
//   Reset: power state off, all detector counters cleared, click_window 60,
//   long_press_limit 150, both channels empty.
//   Stall: while out_stall holds a result, the input register keeps one more
//   item and in_stall rises once both registers are full.
// ----------------------------------------------------------------------------
module button_power_gesture_control_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               key_level,
  input  wire logic                               startup_done,
  input  wire logic                               app_active,
  input  wire logic                               gamepad_active,
  input  wire logic                               remote_active,
  // output channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              power_mode,
  output logic [2:0]                              beep_request,
  output logic [1:0]                              click_event,
  output logic                                    long_press_event,
  // config channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bpg_pkg::CfgIdxBits-1:0]     cfg_index,
  input  wire logic [bpg_pkg::RegBits-1:0]        cfg_data
);

  logic                          s1_valid;
  bpg_pkg::tick_t                s1_tick;
  logic                          s1_fire;
  logic                          in_take;
  bpg_pkg::result_t              res;
  logic [bpg_pkg::RegBits-1:0]   click_window;
  logic [bpg_pkg::RegBits-1:0]   long_press_limit;

  // Handshake control
  assign s1_fire   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_fire;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      click_window     <= bpg_pkg::ClickWindowReset;
      long_press_limit <= bpg_pkg::LongPressLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpg_pkg::CfgClickWindow:    click_window     <= cfg_data;
        bpg_pkg::CfgLongPressLimit: long_press_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_tick.key_level     <= key_level;
      s1_tick.startup_done  <= startup_done;
      s1_tick.others_active <= app_active | gamepad_active | remote_active;
    end
  end

  bpg_detect u_detect (
    .clk              (clk),
    .rst              (rst),
    .fire             (s1_fire),
    .tick             (s1_tick),
    .click_window     (click_window),
    .long_press_limit (long_press_limit),
    .res              (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      power_mode       <= res.power_mode;
      beep_request     <= res.beep_request;
      click_event      <= res.click_event;
      long_press_event <= res.long_press_event;
    end
  end

endmodule : button_power_gesture_control_top
`default_nettype wire

@@ tb/button_power_gesture_control_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_power_gesture_control_top_tb
// Self-checking bench for the button power gesture control block. A local
// gesture predictor tracks power state, hold and click counters per item and
// queues the expected result; a monitor compares every delivered result field
// by field. The run walks the block from off, through a long press to on,
// through single-click and hold traffic, to a double click and switched off,
// under several sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
module button_power_gesture_control_top_tb;

  // Config indexes the block does not decode
  localparam logic [bpg_pkg::CfgIdxBits-1:0] CfgUnusedLo = 2'd2;
  localparam logic [bpg_pkg::CfgIdxBits-1:0] CfgUnusedHi = 2'd3;

  // Predictor state for one gesture controller
  typedef struct packed {
    bpg_pkg::power_state_t                pwr;
    logic [bpg_pkg::HoldBits-1:0]         hold_cnt;
    logic                                 long_block;
    logic                                 key_down_seen;
    logic                                 press_logged;
    logic [bpg_pkg::TallyBits-1:0]        click_tally;
    logic [bpg_pkg::WaitBits-1:0]         wait_cnt;
    logic [bpg_pkg::HeldCounterBits-1:0]  held_cnt;
  } gesture_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           key_level = 1'b1;
  logic                           startup_done = 1'b0;
  logic                           app_active = 1'b0;
  logic                           gamepad_active = 1'b0;
  logic                           remote_active = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     power_mode;
  logic [2:0]                     beep_request;
  logic [1:0]                     click_event;
  logic                           long_press_event;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [bpg_pkg::CfgIdxBits-1:0] cfg_index = bpg_pkg::CfgClickWindow;
  logic [bpg_pkg::RegBits-1:0]    cfg_data = '0;

  // Predictor state, register mirror and expected results
  gesture_state_t              gst;
  logic [bpg_pkg::RegBits-1:0] click_win = bpg_pkg::ClickWindowReset;
  logic [bpg_pkg::RegBits-1:0] lp_limit = bpg_pkg::LongPressLimitReset;
  bpg_pkg::result_t            expected_q[$];

  // Traffic shaping
  int send_gap_pct = 0;
  int stall_pct = 0;
  int gap_pcts[4] = '{0, 64, 0, 14};
  int stall_pcts[4] = '{0, 0, 64, 14};

  // Random press/release run generator
  int   run_left = 0;
  logic run_key = 1'b1;

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int singles_seen = 0;
  int doubles_seen = 0;
  int long_presses = 0;

  button_power_gesture_control_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .key_level(key_level),
    .startup_done(startup_done),
    .app_active(app_active),
    .gamepad_active(gamepad_active),
    .remote_active(remote_active),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .power_mode(power_mode),
    .beep_request(beep_request),
    .click_event(click_event),
    .long_press_event(long_press_event),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Advance the predictor by one tick and return the expected result
  function automatic bpg_pkg::result_t predict_tick(input logic key, input logic started,
                                                    input logic others);
    bpg_pkg::result_t r;
    logic [1:0]       ev;
    logic             done;
    r = '0;
    ev = bpg_pkg::ClickNone;
    done = 1'b0;
    r.beep_request = bpg_pkg::BeepNone;
    if (started && gst.pwr == bpg_pkg::PWR_OFF && !others) begin
      // long-press detector: hold counter saturates, fire blocks one tick
      if (!gst.long_block && !key) begin
        if (gst.hold_cnt != bpg_pkg::HoldMax) gst.hold_cnt = gst.hold_cnt + 1'b1;
      end else begin
        gst.hold_cnt = '0;
      end
      if (gst.hold_cnt > lp_limit) begin
        gst.long_block = 1'b1;
        gst.hold_cnt = '0;
        r.long_press_event = 1'b1;
        r.beep_request = bpg_pkg::BeepOn;
        gst.pwr = bpg_pkg::PWR_ON;
      end else begin
        gst.long_block = 1'b0;
      end
    end else if (gst.pwr == bpg_pkg::PWR_ON && !others) begin
      // click detector
      if (!key) begin
        if (gst.held_cnt != bpg_pkg::HeldMax) gst.held_cnt = gst.held_cnt + 1'b1;
        gst.key_down_seen = 1'b1;
      end else begin
        gst.held_cnt = '0;
      end
      if (!gst.press_logged) begin
        if (gst.key_down_seen) begin
          gst.click_tally = gst.click_tally + 1'b1;
          gst.press_logged = 1'b1;
        end
        if (gst.click_tally == 2'd2) begin
          gst.click_tally = '0;
          gst.wait_cnt = '0;
          ev = bpg_pkg::ClickDouble;
          done = 1'b1;
        end
      end
      if (!done) begin
        if (key) begin
          gst.key_down_seen = 1'b0;
          gst.press_logged = 1'b0;
        end
        if (gst.click_tally == 2'd1) begin
          if (gst.wait_cnt != bpg_pkg::WaitMax) gst.wait_cnt = gst.wait_cnt + 1'b1;
          if (gst.wait_cnt > click_win && gst.held_cnt < click_win) begin
            gst.click_tally = '0;
            gst.wait_cnt = '0;
            ev = bpg_pkg::ClickSingle;
          end else if (gst.held_cnt > click_win) begin
            gst.click_tally = '0;
            gst.wait_cnt = '0;
          end
        end
      end
      if (ev == bpg_pkg::ClickDouble) begin
        r.beep_request = bpg_pkg::BeepOff;
        gst.pwr = bpg_pkg::PWR_SWITCHED_OFF;
      end
    end
    r.power_mode = gst.pwr;
    r.click_event = ev;
    return r;
  endfunction

  // Look ahead without committing: would this tick change the power state?
  function automatic logic would_change_power(input logic key, input logic started,
                                              input logic others);
    gesture_state_t   saved;
    bpg_pkg::result_t r;
    saved = gst;
    r = predict_tick(key, started, others);
    gst = saved;
    return r.power_mode != saved.pwr;
  endfunction

  function automatic void set_traffic(input int phase);
    send_gap_pct = gap_pcts[phase % 4];
    stall_pct = stall_pcts[phase % 4];
  endfunction

  // Present one tick item, hold it until accepted, queue its expected result
  task automatic send_tick(input logic key, input logic started, input logic app,
                           input logic pad, input logic remote);
    bpg_pkg::result_t r;
    while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    key_level <= key;
    startup_done <= started;
    app_active <= app;
    gamepad_active <= pad;
    remote_active <= remote;
    do @(posedge clk); while (in_stall);
    r = predict_tick(key, started, app | pad | remote);
    expected_q.push_back(r);
    items_sent++;
    if (r.click_event == bpg_pkg::ClickSingle) singles_seen++;
    if (r.click_event == bpg_pkg::ClickDouble) doubles_seen++;
    if (r.long_press_event) long_presses++;
  endtask

  // Stop sending and wait for every outstanding result plus pipeline slack
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write while the block is idle
  task automatic write_reg(input logic [bpg_pkg::CfgIdxBits-1:0] idx,
                           input logic [bpg_pkg::RegBits-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bpg_pkg::CfgClickWindow: click_win = val;
      bpg_pkg::CfgLongPressLimit: lp_limit = val;
      default: ;
    endcase
  endtask

  // Well-formed press/release runs with random lengths, plus raw noise;
  // power changes are suppressed by forcing a release
  task automatic random_ticks(input int count);
    int   len_cap;
    logic key;
    logic started;
    logic app;
    logic pad;
    logic remote;
    repeat (count) begin
      if (run_left == 0) begin
        run_key = ~run_key;
        if (gst.pwr == bpg_pkg::PWR_OFF) len_cap = (lp_limit < 30) ? int'(lp_limit) + 3 : 30;
        else len_cap = (click_win < 30) ? int'(click_win) + 3 : 30;
        run_left = $urandom_range(1, len_cap);
      end
      run_left--;
      if ($urandom_range(0, 99) < 15) begin
        {key, started, app, pad, remote} = 5'($urandom);
      end else begin
        key = run_key;
        started = 1'b1;
        app = 1'b0;
        pad = 1'b0;
        remote = 1'b0;
      end
      if (would_change_power(key, started, app | pad | remote)) key = 1'b1;
      send_tick(key, started, app, pad, remote);
    end
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    errors++;
    if (errors <= 40)
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    bpg_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, actual mode %0d beep %0d",
                 $time, power_mode, beep_request);
      end else begin
        want = expected_q.pop_front();
        results_checked++;
        if (power_mode != want.power_mode)
          report_mismatch("power_mode", want.power_mode, power_mode);
        if (beep_request != want.beep_request)
          report_mismatch("beep_request", want.beep_request, beep_request);
        if (click_event != want.click_event)
          report_mismatch("click_event", want.click_event, click_event);
        if (long_press_event != want.long_press_event)
          report_mismatch("long_press_event", want.long_press_event, long_press_event);
      end
    end
  end

  // Off state: startup gating and other control sources freeze the detector
  task automatic test_off_gating;
    set_traffic(0);
    repeat (3) send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    repeat (5) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  // Hold exactly at the limit, a saturated hold counter, and undecoded indexes
  task automatic test_long_press_limits;
    write_reg(bpg_pkg::CfgLongPressLimit, 8'd3);
    write_reg(CfgUnusedLo, 8'd0);
    write_reg(CfgUnusedHi, 8'hFF);
    set_traffic(3);
    repeat (3) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    // a limit of all ones can never be exceeded
    write_reg(bpg_pkg::CfgLongPressLimit, 8'd255);
    set_traffic(0);
    repeat (258) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_off;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(bpg_pkg::CfgLongPressLimit, (ph == 0) ? 8'd1 : 8'($urandom_range(2, 20)));
      write_reg(bpg_pkg::CfgClickWindow, 8'($urandom));
      set_traffic(ph);
      random_ticks(20);
    end
  endtask

  // Long press just past the limit switches the power on
  task automatic test_switch_on;
    write_reg(bpg_pkg::CfgLongPressLimit, 8'd30);
    write_reg(bpg_pkg::CfgClickWindow, 8'd5);
    set_traffic(0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    while (gst.pwr == bpg_pkg::PWR_OFF) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  // Single click, holds around the window, and window extremes
  task automatic test_click_detector;
    set_traffic(3);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (7) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (6) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (2) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    // held exactly the window length
    repeat (5) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    repeat (8) send_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    write_reg(bpg_pkg::CfgClickWindow, 8'd0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    write_reg(bpg_pkg::CfgClickWindow, 8'd255);
    set_traffic(0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (258) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  // Hold well past the click window: the pending press is dropped
  task automatic test_long_hold;
    write_reg(bpg_pkg::CfgClickWindow, 8'd4);
    set_traffic(2);
    repeat (10) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (3) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_on;
    logic [bpg_pkg::RegBits-1:0] win;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 1) win = 8'd0;
      else if (ph == 4) win = 8'd255;
      else win = 8'($urandom_range(1, 12));
      write_reg(bpg_pkg::CfgClickWindow, win);
      write_reg(bpg_pkg::CfgLongPressLimit, 8'($urandom));
      set_traffic(ph);
      random_ticks(20);
    end
  endtask

  // Two presses inside the window switch the power off
  task automatic test_double_click;
    write_reg(bpg_pkg::CfgClickWindow, 8'd10);
    set_traffic(3);
    while (gst.click_tally != 0 || gst.key_down_seen)
      send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (2) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    repeat (2) send_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
  endtask

  // Switched off is terminal: nothing moves it
  task automatic test_switched_off;
    write_reg(bpg_pkg::CfgLongPressLimit, 8'd1);
    for (int ph = 0; ph < 4; ph++) begin
      set_traffic(ph);
      random_ticks(10);
    end
  endtask

  initial begin
    gst = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_off_gating();
    test_long_press_limits();
    test_random_off();
    test_switch_on();
    test_click_detector();
    test_long_hold();
    test_random_on();
    test_double_click();
    test_switched_off();
    set_traffic(0);
    drain();
    $display("Sent %0d ticks, checked %0d results: %0d long press, %0d single, %0d double.",
             items_sent, results_checked, long_presses, singles_seen, doubles_seen);
    $display("Covered off gating, hold limits, click windows, long holds, switch off.");
    if (errors == 0) begin
      $display("button_power_gesture_control_top_tb: PASS");
    end else begin
      $display("button_power_gesture_control_top_tb: FAIL");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("button_power_gesture_control_top_tb: FAIL");
    $finish;
  end

endmodule
